// File: rtl/ccp_pkg.sv
// Shared types, codes and tag decode for the constant-pool parser.
package ccp_pkg;

  localparam int unsigned SlotW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned AccW   = 64;
  localparam int unsigned CntW   = 4;

  localparam logic [SlotW-1:0] SlotMax       = 16'hFFFF;
  localparam logic [SlotW-1:0] PoolCountRst  = 16'd1;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Class-file tag numbers
  localparam logic [ByteW-1:0] TagUtf8       = 8'd1;
  localparam logic [ByteW-1:0] TagInteger    = 8'd3;
  localparam logic [ByteW-1:0] TagFloat      = 8'd4;
  localparam logic [ByteW-1:0] TagLong       = 8'd5;
  localparam logic [ByteW-1:0] TagDouble     = 8'd6;
  localparam logic [ByteW-1:0] TagClass      = 8'd7;
  localparam logic [ByteW-1:0] TagString     = 8'd8;
  localparam logic [ByteW-1:0] TagFieldRef   = 8'd9;
  localparam logic [ByteW-1:0] TagMethodRef  = 8'd10;
  localparam logic [ByteW-1:0] TagIfMethRef  = 8'd11;
  localparam logic [ByteW-1:0] TagNameType   = 8'd12;
  localparam logic [ByteW-1:0] TagMethHandle = 8'd15;
  localparam logic [ByteW-1:0] TagMethType   = 8'd16;
  localparam logic [ByteW-1:0] TagInvokeDyn  = 8'd18;

  typedef enum logic [3:0] {
    PH_TAG    = 4'b0001,
    PH_FIELDS = 4'b0010,
    PH_TEXT   = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_e;

  typedef struct packed {
    kind_e             kind;
    logic [SlotW-1:0]  slot_index;
    logic [ByteW-1:0]  entry_tag;
    logic [WordW-1:0]  first_value;
    logic [WordW-1:0]  second_value;
    logic [ByteW-1:0]  content_byte;
    logic              last_of_pool;
  } result_t;

  // Body length in bytes; zero marks an unknown tag.
  function automatic logic [CntW-1:0] body_size(input logic [ByteW-1:0] tag);
    logic [CntW-1:0] sz;
    case (tag)
      TagUtf8, TagClass, TagString, TagMethType: sz = 4'd2;
      TagMethHandle: sz = 4'd3;
      TagInteger, TagFloat, TagFieldRef, TagMethodRef, TagIfMethRef,
      TagNameType, TagInvokeDyn: sz = 4'd4;
      TagLong, TagDouble: sz = 4'd8;
      default: sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage

// File: rtl/ccp_if.sv
// Stream interfaces: byte input channel and result output channel.
interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       restart;

  modport source (output valid, output stream_byte, output restart, input ready);
  modport sink   (input valid, input stream_byte, input restart, output ready);
endinterface

interface ccp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] slot_index;
  logic [7:0]  entry_tag;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic [7:0]  content_byte;
  logic        last_of_pool;

  modport source (output valid, output kind, output slot_index, output entry_tag,
                  output first_value, output second_value, output content_byte,
                  output last_of_pool, input ready);
  modport sink   (input valid, input kind, input slot_index, input entry_tag,
                  input first_value, input second_value, input content_byte,
                  input last_of_pool, output ready);
endinterface

// File: rtl/ccp_parser.sv
// Parse state and per-byte result logic.
module ccp_parser
  import ccp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [ByteW-1:0]  stream_byte_i,
  input  logic              restart_i,
  input  logic [SlotW-1:0]  pool_count_i,
  output logic              res_vld_o,
  output result_t           res_o
);

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  tag_q, tag_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [SlotW-1:0]  rem_q, rem_d;
  logic [SlotW-1:0]  slot_q, slot_d;

  phase_e            cur_phase;
  logic [ByteW-1:0]  cur_tag;
  logic [CntW-1:0]   cur_cnt;
  logic [AccW-1:0]   cur_acc;
  logic [SlotW-1:0]  cur_rem;
  logic [SlotW-1:0]  cur_slot;

  logic [CntW-1:0]   size_tag, size_byte, cnt_inc;
  logic [AccW-1:0]   acc_shift;
  logic [WordW-1:0]  first, second;
  logic [SlotW:0]    slot_sum;
  logic [SlotW-1:0]  slot_adv;
  logic              two_slot;
  logic [SlotW-1:0]  rem_dec;

  always_comb begin
    // restart takes effect before the byte is parsed
    if (restart_i) begin
      cur_phase = PH_TAG;
      cur_tag   = '0;
      cur_cnt   = '0;
      cur_acc   = '0;
      cur_rem   = '0;
      cur_slot  = SlotW'(1);
    end else begin
      cur_phase = phase_q;
      cur_tag   = tag_q;
      cur_cnt   = cnt_q;
      cur_acc   = acc_q;
      cur_rem   = rem_q;
      cur_slot  = slot_q;
    end
  end

  assign size_tag  = body_size(cur_tag);
  assign size_byte = body_size(stream_byte_i);
  assign cnt_inc   = cur_cnt + CntW'(1);
  assign acc_shift = {cur_acc[AccW-ByteW-1:0], stream_byte_i};
  assign two_slot  = (cur_tag == TagLong) || (cur_tag == TagDouble);
  assign rem_dec   = (cur_rem != '0) ? cur_rem - SlotW'(1) : cur_rem;

  // Field split of a finished body
  always_comb begin
    if (size_tag == 4'd8) begin
      first  = acc_shift[63:32];
      second = acc_shift[31:0];
    end else if (size_tag == 4'd3) begin
      first  = {24'd0, acc_shift[23:16]};
      second = {16'd0, acc_shift[15:0]};
    end else if (size_tag == 4'd4 && cur_tag != TagInteger && cur_tag != TagFloat) begin
      first  = {16'd0, acc_shift[31:16]};
      second = {16'd0, acc_shift[15:0]};
    end else begin
      first  = acc_shift[31:0];
      second = '0;
    end
  end

  // Saturating slot advance; text and single-slot tags step by one
  always_comb begin
    if (cur_phase == PH_FIELDS && two_slot) begin
      slot_sum = {1'b0, cur_slot} + (SlotW+1)'(2);
    end else begin
      slot_sum = {1'b0, cur_slot} + (SlotW+1)'(1);
    end
    slot_adv = slot_sum[SlotW] ? SlotMax : slot_sum[SlotW-1:0];
  end

  always_comb begin
    phase_d   = cur_phase;
    tag_d     = cur_tag;
    cnt_d     = cur_cnt;
    acc_d     = cur_acc;
    rem_d     = cur_rem;
    slot_d    = cur_slot;
    res_vld_o = 1'b0;
    res_o     = '0;
    res_o.slot_index = cur_slot;

    case (cur_phase)
      PH_TAG: begin
        if (cur_slot < pool_count_i) begin
          if (size_byte == '0) begin
            phase_d         = PH_HALT;
            res_vld_o       = 1'b1;
            res_o.kind      = KIND_ERROR;
            res_o.entry_tag = stream_byte_i;
          end else begin
            tag_d   = stream_byte_i;
            cnt_d   = '0;
            acc_d   = '0;
            phase_d = PH_FIELDS;
          end
        end
      end
      PH_FIELDS: begin
        acc_d = acc_shift;
        cnt_d = cnt_inc;
        if (cnt_inc >= size_tag) begin
          res_vld_o          = 1'b1;
          res_o.kind         = KIND_ENTRY;
          res_o.entry_tag    = cur_tag;
          res_o.first_value  = first;
          res_o.second_value = second;
          cnt_d              = '0;
          if (cur_tag == TagUtf8 && first != '0) begin
            rem_d   = first[SlotW-1:0];
            phase_d = PH_TEXT;
          end else begin
            slot_d             = slot_adv;
            res_o.last_of_pool = (slot_adv >= pool_count_i);
            phase_d            = PH_TAG;
          end
        end
      end
      PH_TEXT: begin
        res_vld_o          = 1'b1;
        res_o.kind         = KIND_TEXT;
        res_o.entry_tag    = TagUtf8;
        res_o.content_byte = stream_byte_i;
        rem_d              = rem_dec;
        if (rem_dec == '0) begin
          slot_d             = slot_adv;
          res_o.last_of_pool = (slot_adv >= pool_count_i);
          phase_d            = PH_TAG;
        end
      end
      PH_HALT: begin
      end
      default: begin
        phase_d = PH_TAG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      tag_q   <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      rem_q   <= '0;
      slot_q  <= SlotW'(1);
    end else if (accept_i) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      slot_q  <= slot_d;
    end
  end

endmodule

// File: rtl/ccp_out_reg.sv
// Output result register driving the result channel.
module ccp_out_reg
  import ccp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  result_t      res_i,
  output logic         free_o,
  ccp_out_if.source    res_o
);

  logic    vld_q;
  result_t data_q;

  // free when empty or the held beat leaves this cycle
  assign free_o = !vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (res_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.kind         = data_q.kind;
  assign res_o.slot_index   = data_q.slot_index;
  assign res_o.entry_tag    = data_q.entry_tag;
  assign res_o.first_value  = data_q.first_value;
  assign res_o.second_value = data_q.second_value;
  assign res_o.content_byte = data_q.content_byte;
  assign res_o.last_of_pool = data_q.last_of_pool;

endmodule

// File: rtl/class_constant_pool_parser_core.sv
// Top level of the class-file constant-pool stream parser.
//
// Usage:
//   in_i   carries the constant-pool stream, one byte per beat, with restart
//          high on the first tag byte of a new pool.
//   res_o  carries at most one result per input beat: an entry record, a
//          UTF-8 content byte, or an unknown-tag error.
//   cfg_we_i/cfg_wdata_i write pool_count; write only while the block is idle.
// Output: a result is registered and appears on res_o in the cycle after
//   the byte that finishes it. Throughput: one byte per cycle while the
//   output register can move, for tag, field and text bytes alike.
// Stall: results sit in a single output register; while it is full and the
//   receiver holds ready low, in_i.ready drops and no byte is taken. A byte
//   that produces no result is still taken whenever that register can move.
// Reset: parser expects a tag, slot index 1, no error, pool_count 1 (empty
//   pool), output register empty.
// An unknown tag halts the parser until a beat with restart set.
module class_constant_pool_parser_core
  import ccp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SlotW-1:0]  cfg_wdata_i,
  ccp_in_if.sink            in_i,
  ccp_out_if.source         res_o
);

  logic [SlotW-1:0] pool_count_q;
  logic             accept;
  logic             out_free;
  logic             res_vld;
  result_t          res;

  // pool_count register, compared live at each tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_count_q <= PoolCountRst;
    end else if (cfg_we_i) begin
      pool_count_q <= cfg_wdata_i;
    end
  end

  // take a byte whenever its possible result has somewhere to go
  assign in_i.ready = out_free;
  assign accept     = in_i.valid && out_free;

  ccp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (in_i.stream_byte),
    .restart_i     (in_i.restart),
    .pool_count_i  (pool_count_q),
    .res_vld_o     (res_vld),
    .res_o         (res)
  );

  ccp_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept && res_vld),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule

// File: bench/ccp_pool_checker.sv
// Result checker for the constant-pool parser: tracks the byte stream and compares every result beat.
module ccp_pool_checker
  import ccp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SlotW-1:0] cfg_wdata_i,
  ccp_in_if                in_mon,
  ccp_out_if               res_mon,
  output int unsigned      mismatch_cnt_o,
  output int unsigned      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {AWAIT_TAG, IN_FIELDS, IN_TEXT, HALTED} parse_state_e;

  parse_state_e     state      = AWAIT_TAG;
  logic [ByteW-1:0] held_tag   = '0;
  logic [CntW-1:0]  body_cnt   = '0;
  logic [AccW-1:0]  body_acc   = '0;
  logic [SlotW-1:0] text_left  = '0;
  logic [SlotW-1:0] slot_nxt   = 16'd1;
  logic [SlotW-1:0] pool_limit = PoolCountRst;
  result_t          expected_results[$];

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  // Bytes of body that follow each tag; zero for a tag the format does not define.
  function automatic logic [CntW-1:0] body_len(input logic [ByteW-1:0] tag);
    unique case (tag)
      TagLong, TagDouble:                      return 4'd8;
      TagInteger, TagFloat, TagNameType,
      TagFieldRef, TagMethodRef, TagIfMethRef,
      TagInvokeDyn:                            return 4'd4;
      TagMethHandle:                           return 4'd3;
      TagClass, TagString, TagMethType,
      TagUtf8:                                 return 4'd2;
      default:                                 return 4'd0;
    endcase
  endfunction

  // Moves the slot pointer on, saturating at the top; flags the end of the pool.
  function automatic logic take_slots(input logic [1:0] n);
    logic [SlotW:0] sum;
    sum      = {1'b0, slot_nxt} + n;
    slot_nxt = sum[SlotW] ? SlotMax : sum[SlotW-1:0];
    return slot_nxt >= pool_limit;
  endfunction

  // Advances the parse by one stream byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [ByteW-1:0] b, input logic rs,
                                    output result_t r);
    logic [CntW-1:0]  need;
    logic [WordW-1:0] w1, w2;
    r = '0;
    if (rs) begin
      state     = AWAIT_TAG;
      held_tag  = '0;
      body_cnt  = '0;
      body_acc  = '0;
      text_left = '0;
      slot_nxt  = 16'd1;
    end
    case (state)
      AWAIT_TAG: begin
        if (slot_nxt >= pool_limit) return 1'b0;
        if (body_len(b) == 0) begin
          state        = HALTED;
          r.kind       = KIND_ERROR;
          r.slot_index = slot_nxt;
          r.entry_tag  = b;
          return 1'b1;
        end
        held_tag = b;
        body_cnt = '0;
        body_acc = '0;
        state    = IN_FIELDS;
        return 1'b0;
      end
      IN_FIELDS: begin
        need     = body_len(held_tag);
        body_acc = {body_acc[AccW-9:0], b};
        body_cnt = body_cnt + 1'b1;
        if (body_cnt < need) return 1'b0;
        if (need == 4'd8) begin
          w1 = body_acc[63:32];
          w2 = body_acc[31:0];
        end else if (need == 4'd3) begin
          w1 = {24'd0, body_acc[23:16]};
          w2 = {16'd0, body_acc[15:0]};
        end else if (need == 4'd4 && held_tag != TagInteger && held_tag != TagFloat) begin
          w1 = {16'd0, body_acc[31:16]};
          w2 = {16'd0, body_acc[15:0]};
        end else begin
          w1 = body_acc[31:0];
          w2 = '0;
        end
        r.kind         = KIND_ENTRY;
        r.slot_index   = slot_nxt;
        r.entry_tag    = held_tag;
        r.first_value  = w1;
        r.second_value = w2;
        body_cnt       = '0;
        if (held_tag == TagUtf8 && w1 != 0) begin
          text_left = w1[SlotW-1:0];
          state     = IN_TEXT;
        end else begin
          r.last_of_pool = take_slots((held_tag == TagLong || held_tag == TagDouble) ? 2'd2 : 2'd1);
          state          = AWAIT_TAG;
        end
        return 1'b1;
      end
      IN_TEXT: begin
        r.kind         = KIND_TEXT;
        r.slot_index   = slot_nxt;
        r.entry_tag    = TagUtf8;
        r.content_byte = b;
        if (text_left != 0) text_left = text_left - 1'b1;
        if (text_left == 0) begin
          r.last_of_pool = take_slots(2'd1);
          state          = AWAIT_TAG;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_result_beat();
    result_t got, want;
    got = {res_mon.kind, res_mon.slot_index, res_mon.entry_tag, res_mon.first_value,
           res_mon.second_value, res_mon.content_byte, res_mon.last_of_pool};
    if (expected_results.size() == 0) begin
      if (mismatch_cnt_o < 10)
        $display("%0t: result beat with nothing predicted, kind %0d slot %0d tag %0d",
                 $realtime, got.kind, got.slot_index, got.entry_tag);
      mismatch_cnt_o++;
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        if (mismatch_cnt_o < 10) begin
          $display("%0t: result beat differs (exp/got) kind %0d/%0d slot %0d/%0d tag %0d/%0d",
                   $realtime, want.kind, got.kind, want.slot_index, got.slot_index,
                   want.entry_tag, got.entry_tag);
          $display("  first %h/%h second %h/%h byte %h/%h last %0d/%0d",
                   want.first_value, got.first_value, want.second_value, got.second_value,
                   want.content_byte, got.content_byte, want.last_of_pool, got.last_of_pool);
        end
        mismatch_cnt_o++;
      end
    end
  endtask

  // Results are registered before they leave, so a result beat never belongs to the
  // byte taken at the same edge: check first, then predict.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t r;
    if (!rst_ni) begin
      state      = AWAIT_TAG;
      held_tag   = '0;
      body_cnt   = '0;
      body_acc   = '0;
      text_left  = '0;
      slot_nxt   = 16'd1;
      pool_limit = PoolCountRst;
      expected_results.delete();
    end else begin
      if (cfg_we_i) pool_limit = cfg_wdata_i;
      if (res_mon.valid && res_mon.ready) check_result_beat();
      if (in_mon.valid && in_mon.ready) begin
        if (parse_byte(in_mon.stream_byte, in_mon.restart, r)) expected_results.push_back(r);
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// File: bench/tb_class_constant_pool_parser_core.sv
// Testbench top for the constant-pool parser: clock, reset, byte stimulus and verdict.
module tb_class_constant_pool_parser_core;
  import ccp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Nothing accepted on either side for this long means the block has hung.
  localparam int unsigned StallLimit  = 2000;
  // Rough size of the random part, in stream bytes.
  localparam int unsigned RandomBytes = 1300;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [SlotW-1:0] cfg_wdata;
  int unsigned      mismatch_cnt;
  int unsigned      pending;
  int unsigned      quiet_cycles;
  int unsigned      bytes_sent;
  bit               idle_on;

  ccp_in_if  in_ch ();
  ccp_out_if res_ch ();

  class_constant_pool_parser_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .res_o       (res_ch)
  );

  ccp_pool_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_mon         (in_ch),
    .res_mon        (res_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready is redrawn every falling edge; held high while idling is off.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= !(idle_on && $urandom_range(99) < 37);
    end
  end

  // Hang detection: count cycles in which neither channel moves a beat.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("Mismatches found");
    $finish;
  end

  // Field bytes lean on the all-zero and all-one patterns.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void pick_known_tag(output logic [7:0] tag, output int unsigned blen);
    case ($urandom_range(13))
      0:       begin tag = TagUtf8;       blen = 2; end
      1:       begin tag = TagInteger;    blen = 4; end
      2:       begin tag = TagFloat;      blen = 4; end
      3:       begin tag = TagLong;       blen = 8; end
      4:       begin tag = TagDouble;     blen = 8; end
      5:       begin tag = TagClass;      blen = 2; end
      6:       begin tag = TagString;     blen = 2; end
      7:       begin tag = TagFieldRef;   blen = 4; end
      8:       begin tag = TagMethodRef;  blen = 4; end
      9:       begin tag = TagIfMethRef;  blen = 4; end
      10:      begin tag = TagNameType;   blen = 4; end
      11:      begin tag = TagMethHandle; blen = 3; end
      12:      begin tag = TagMethType;   blen = 2; end
      default: begin tag = TagInvokeDyn;  blen = 4; end
    endcase
  endfunction

  // One beat on the byte channel. Valid may first be held low at random; once
  // raised it stays up with the payload held until the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic rs);
    while (idle_on && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.stream_byte <= b;
    in_ch.restart     <= rs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Lets the pipeline drain so the count register is written with the block idle.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_pool_count(input logic [SlotW-1:0] v);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One entry with random content. cut reports an entry left unfinished on purpose
  // (truncated body or unknown tag), after which the caller ends that pool.
  task automatic send_entry(input logic rs, output bit cut);
    logic [7:0]  tag;
    logic [7:0]  body[$];
    int unsigned blen, tlen, keep;
    cut = 1'b0;
    if ($urandom_range(99) < 4) begin
      // Unknown tag: mostly the holes among the low numbers, sometimes anything.
      tag = ($urandom_range(1) == 0) ? 8'($urandom_range(24)) : 8'($urandom);
      while (tag inside {TagUtf8, TagInteger, TagFloat, TagLong, TagDouble, TagClass,
                         TagString, TagFieldRef, TagMethodRef, TagIfMethRef,
                         TagNameType, TagMethHandle, TagMethType, TagInvokeDyn})
        tag = 8'($urandom_range(24));
      send_byte(tag, rs);
      // Zero to two bytes that the halted parser must swallow.
      repeat ($urandom_range(2)) send_byte(rand_byte(), 1'b0);
      cut = 1'b1;
      return;
    end
    pick_known_tag(tag, blen);
    if (tag == TagUtf8) begin
      tlen = ($urandom_range(19) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
      body.push_back(8'(tlen >> 8));
      body.push_back(8'(tlen));
      repeat (tlen) body.push_back(rand_byte());
    end else begin
      repeat (blen) body.push_back(rand_byte());
    end
    keep = body.size();
    if ($urandom_range(99) < 3) begin
      keep = $urandom_range(body.size() - 1);
      cut  = 1'b1;
    end
    send_byte(tag, rs);
    for (int unsigned i = 0; i < keep; i++) send_byte(body[i], 1'b0);
  endtask

  task automatic send_pool(input int unsigned entries, input bit fresh);
    bit   cut;
    logic rs;
    rs = fresh;
    for (int unsigned e = 0; e < entries; e++) begin
      send_entry(rs, cut);
      rs = 1'b0;
      if (cut) break;
    end
  endtask

  initial begin
    logic [SlotW-1:0] limit;
    int unsigned      pools, entries;
    int unsigned      phase_idx;

    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.stream_byte = '0;
    in_ch.restart     = 1'b0;
    idle_on           = 1'b1;
    bytes_sent        = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // --- Directed part ---------------------------------------------------
    // Count is 1 out of reset: empty pool, the tag is dropped with no result.
    send_byte(TagClass, 1'b1);

    // Two-slot double on the only slot: record carries last_of_pool, and the
    // byte after it falls into a finished pool.
    write_pool_count(16'd2);
    send_byte(TagDouble, 1'b1);
    repeat (4) send_byte(8'hFF, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);
    send_byte(TagNameType, 1'b0);

    // Unknown tags at both ends of the byte range; the parser halts in between.
    send_byte(8'h00, 1'b1);
    send_byte(TagUtf8, 1'b0);
    send_byte(8'hFF, 1'b1);

    // UTF-8 of length one, then the zero-length case that finishes at once.
    send_byte(TagUtf8, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(TagUtf8, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);

    // A count of zero is also an empty pool.
    write_pool_count(16'd0);
    send_byte(TagClass, 1'b1);

    // --- Random part -----------------------------------------------------
    // Each phase picks a count, then sends one pool, or three if the count is two or more.
    // Most pools are well formed and, for small counts, sized near the count so that
    // they run to completion; a few are pure noise, truncated, or hit an unknown tag.
    for (phase_idx = 0; bytes_sent < RandomBytes; phase_idx++) begin
      case (phase_idx)
        1:       limit = SlotMax;
        2:       limit = PoolCountRst;
        4:       limit = 16'd0;
        default: limit = (phase_idx % 4 == 2) ? 16'($urandom_range(30, 300))
                                              : 16'($urandom_range(2, 24));
      endcase
      // One phase runs flat out on both sides.
      idle_on = (phase_idx != 3);
      write_pool_count(limit);
      pools = (limit < 2) ? 1 : 3;
      for (int unsigned p = 0; p < pools; p++) begin
        if ($urandom_range(15) == 0) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(3) == 0));
        end else begin
          entries = (limit < 2) ? 3 : ((limit - 1 < 12) ? limit - 1 : 12) + $urandom_range(2);
          // The first pool of a phase sometimes carries on from where the last left off,
          // which exercises a count changed in the middle of a pool.
          send_pool(entries, (p != 0) || ($urandom_range(4) != 0));
        end
      end
    end

    // --- Wind down -------------------------------------------------------
    idle_on = 1'b1;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatch_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ccp_pkg.sv
rtl/ccp_if.sv
rtl/ccp_parser.sv
rtl/ccp_out_reg.sv
rtl/class_constant_pool_parser_core.sv
bench/ccp_pool_checker.sv
bench/tb_class_constant_pool_parser_core.sv
